### hw/rtl/lle_pkg.sv
// lle_pkg: shared constants, codes and transaction types of the linked list engine
// depends on nothing; used by linked_list_engine_core and linked_list_engine_core_tb

package lle_pkg;

    localparam int CAPACITY = 256;
    localparam int PTR_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    typedef enum logic [OP_W-1:0] {
        OP_ADD_HEAD  = 3'd0,
        OP_ADD_TAIL  = 3'd1,
        OP_TAKE_HEAD = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_FIND      = 3'd4,
        OP_CLEAR     = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value_out;
        logic [INDEX_W-1:0]        index_out;
    } result_t;

endpackage

### hw/rtl/linked_list_engine_core.sv
// linked_list_engine_core: singly linked list engine over a node store in two rams
// depends on lle_pkg and lle_ram
//
//  channel  | direction | payload            | handshake
//  ---------+-----------+--------------------+--------------------------
//  item     | in        | lle_pkg::item_t    | item_valid / item_stall
//  result   | out       | lle_pkg::result_t  | result_valid / result_stall
//
// one transaction at a time; item_stall is high from acceptance until its result is taken
// clear, full push, empty pop or walk, and spare codes give their result straight from idle;
// push goes through grab (only when the node comes off the free list), push write and, for
// a tail link, link tail; pop goes through pop and release; remove and find read one node
// per cycle (single read port), and remove then writes in unlink (not at the head), release
// reset clears state, pointers, valid flag; nodes are always written before they are read

module linked_list_engine_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  lle_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output lle_pkg::result_t result
);

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_GRAB      = 8'b0000_0010,
        S_PUSH_WR   = 8'b0000_0100,
        S_LINK_TAIL = 8'b0000_1000,
        S_POP       = 8'b0001_0000,
        S_WALK      = 8'b0010_0000,
        S_UNLINK    = 8'b0100_0000,
        S_RELEASE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // list control state
    logic [lle_pkg::PTR_W-1:0] first_reg, first_next;
    logic [lle_pkg::PTR_W-1:0] last_reg, last_next;
    logic [lle_pkg::PTR_W-1:0] free_reg, free_next;
    logic [lle_pkg::PTR_W-1:0] mark_reg, mark_next;
    logic                      out_valid_reg, out_valid_next;

    // per-transaction working registers
    logic [lle_pkg::OP_W-1:0]           op_reg, op_next;
    logic signed [lle_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [lle_pkg::PTR_W-1:0]          cur_reg, cur_next;
    logic [lle_pkg::PTR_W-1:0]          prev_reg, prev_next;
    logic [lle_pkg::PTR_W-1:0]          link_reg, link_next;
    logic [lle_pkg::PTR_W-1:0]          step_reg, step_next;
    lle_pkg::result_t                   res_reg, res_next;

    // node store ports
    logic                               vals_we;
    logic [lle_pkg::VALUE_W-1:0]        vals_rdata;
    logic                               links_we;
    logic [lle_pkg::ADDR_W-1:0]         links_waddr;
    logic [lle_pkg::PTR_W-1:0]          links_wdata;
    logic [lle_pkg::PTR_W-1:0]          links_rdata;
    logic [lle_pkg::ADDR_W-1:0]         rd_addr;

    logic                      accept;
    logic [lle_pkg::PTR_W-1:0] rd_link;
    logic [lle_pkg::PTR_W-1:0] step_inc;

    function automatic logic [lle_pkg::PTR_W-1:0] clamp_ptr(input logic [lle_pkg::PTR_W-1:0] p);
        return (p < lle_pkg::NIL) ? p : lle_pkg::NIL;
    endfunction

    assign item_stall   = (state_reg != S_IDLE) || out_valid_reg;
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = res_reg;

    assign rd_link  = clamp_ptr(links_rdata);
    assign step_inc = step_reg + 1'b1;

    lle_ram #(
        .WIDTH(lle_pkg::VALUE_W),
        .DEPTH(lle_pkg::CAPACITY)
    ) u_values (
        .clk   (clk),
        .we    (vals_we),
        .waddr (cur_reg[lle_pkg::ADDR_W-1:0]),
        .wdata (val_reg),
        .raddr (rd_addr),
        .rdata (vals_rdata)
    );

    lle_ram #(
        .WIDTH(lle_pkg::PTR_W),
        .DEPTH(lle_pkg::CAPACITY)
    ) u_links (
        .clk   (clk),
        .we    (links_we),
        .waddr (links_waddr),
        .wdata (links_wdata),
        .raddr (rd_addr),
        .rdata (links_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        free_next      = free_reg;
        mark_next      = mark_reg;
        out_valid_next = out_valid_reg && result_stall;
        op_next        = op_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        link_next      = link_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        vals_we        = 1'b0;
        links_we       = 1'b0;
        links_waddr    = cur_reg[lle_pkg::ADDR_W-1:0];
        links_wdata    = lle_pkg::NIL;
        rd_addr        = cur_reg[lle_pkg::ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                // prefetch: free list head for pushes, list head otherwise
                if (item.op == lle_pkg::OP_ADD_HEAD || item.op == lle_pkg::OP_ADD_TAIL)
                begin
                    rd_addr = free_reg[lle_pkg::ADDR_W-1:0];
                end
                else
                begin
                    rd_addr = first_reg[lle_pkg::ADDR_W-1:0];
                end

                if (accept)
                begin
                    op_next   = item.op;
                    val_next  = item.value;
                    prev_next = lle_pkg::NIL;
                    step_next = '0;
                    res_next  = '{status: lle_pkg::ST_OK, value_out: '0, index_out: '0};

                    unique case (item.op)
                        lle_pkg::OP_ADD_HEAD, lle_pkg::OP_ADD_TAIL:
                        begin
                            if (free_reg < lle_pkg::NIL)
                            begin
                                cur_next   = free_reg;
                                state_next = S_GRAB;
                            end
                            else if (mark_reg < lle_pkg::NIL)
                            begin
                                cur_next   = mark_reg;
                                mark_next  = mark_reg + 1'b1;
                                state_next = S_PUSH_WR;
                            end
                            else
                            begin
                                res_next.status = lle_pkg::ST_FULL;
                                out_valid_next  = 1'b1;
                            end
                        end
                        lle_pkg::OP_TAKE_HEAD:
                        begin
                            if (first_reg < lle_pkg::NIL)
                            begin
                                cur_next   = first_reg;
                                state_next = S_POP;
                            end
                            else
                            begin
                                res_next.status = lle_pkg::ST_EMPTY;
                                out_valid_next  = 1'b1;
                            end
                        end
                        lle_pkg::OP_REMOVE, lle_pkg::OP_FIND:
                        begin
                            if (first_reg < lle_pkg::NIL)
                            begin
                                cur_next   = first_reg;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                res_next.status = lle_pkg::ST_NOT_FOUND;
                                out_valid_next  = 1'b1;
                            end
                        end
                        lle_pkg::OP_CLEAR:
                        begin
                            first_next     = lle_pkg::NIL;
                            last_next      = lle_pkg::NIL;
                            free_next      = lle_pkg::NIL;
                            mark_next      = '0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            // unused codes change nothing
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_GRAB:
            begin
                // node taken off the free list
                free_next  = rd_link;
                state_next = S_PUSH_WR;
            end

            S_PUSH_WR:
            begin
                vals_we  = 1'b1;
                links_we = 1'b1;
                if (op_reg == lle_pkg::OP_ADD_HEAD)
                begin
                    links_wdata = first_reg;
                    if (first_reg >= lle_pkg::NIL)
                    begin
                        last_next = cur_reg;
                    end
                    first_next     = cur_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (last_reg < lle_pkg::NIL)
                begin
                    state_next = S_LINK_TAIL;
                end
                else
                begin
                    last_next = cur_reg;
                    if (first_reg >= lle_pkg::NIL)
                    begin
                        first_next = cur_reg;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_LINK_TAIL:
            begin
                links_we       = 1'b1;
                links_waddr    = last_reg[lle_pkg::ADDR_W-1:0];
                links_wdata    = cur_reg;
                last_next      = cur_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            S_POP:
            begin
                res_next.value_out = vals_rdata;
                first_next         = rd_link;
                if (rd_link >= lle_pkg::NIL)
                begin
                    last_next = lle_pkg::NIL;
                end
                state_next = S_RELEASE;
            end

            S_WALK:
            begin
                // node data for cur_reg arrives this cycle
                if (vals_rdata == val_reg)
                begin
                    if (op_reg == lle_pkg::OP_FIND)
                    begin
                        res_next.index_out = lle_pkg::INDEX_W'(step_reg);
                        out_valid_next     = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        res_next.value_out = vals_rdata;
                        if (prev_reg >= lle_pkg::NIL)
                        begin
                            first_next = rd_link;
                            if (rd_link >= lle_pkg::NIL)
                            begin
                                last_next = lle_pkg::NIL;
                            end
                            state_next = S_RELEASE;
                        end
                        else
                        begin
                            link_next = rd_link;
                            if (cur_reg == last_reg)
                            begin
                                last_next = prev_reg;
                            end
                            state_next = S_UNLINK;
                        end
                    end
                end
                else if (rd_link >= lle_pkg::NIL || step_inc >= lle_pkg::NIL)
                begin
                    res_next.status = lle_pkg::ST_NOT_FOUND;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    // follow the link, fetch the next node
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    step_next = step_inc;
                    rd_addr   = rd_link[lle_pkg::ADDR_W-1:0];
                end
            end

            S_UNLINK:
            begin
                links_we    = 1'b1;
                links_waddr = prev_reg[lle_pkg::ADDR_W-1:0];
                links_wdata = link_reg;
                state_next  = S_RELEASE;
            end

            S_RELEASE:
            begin
                // removed node goes onto the free list
                links_we       = 1'b1;
                links_wdata    = free_reg;
                free_next      = cur_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= lle_pkg::NIL;
            last_reg      <= lle_pkg::NIL;
            free_reg      <= lle_pkg::NIL;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            free_reg      <= free_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        val_reg  <= val_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        link_reg <= link_next;
        step_reg <= step_next;
        res_reg  <= res_next;
    end

    // a pending result only ever waits with the sequencer idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_IDLE)
        else $error("result pending while sequencer busy");

    // head and tail are empty together
    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (first_reg == lle_pkg::NIL) == (last_reg == lle_pkg::NIL))
        else $error("head and tail pointers disagree on empty list");

    // never-used mark stays within the store
    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        mark_reg <= lle_pkg::NIL)
        else $error("never-used mark beyond capacity");

    // an accepted transaction either starts work or produces its result
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE) || out_valid_reg)
        else $error("accepted transaction dropped");

endmodule

### hw/rtl/lle_ram.sv
// lle_ram: generic single write port, single read port ram with registered read
// no dependencies

module lle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/sv/linked_list_engine_core_tb.sv
`timescale 1ns / 1ps
// linked_list_engine_core_tb: self-checking bench for the linked list engine core
// depends on lle_pkg and linked_list_engine_core; a directed table runs first, then random
// segments, checked against a queue-based mirror of the list or the table's own expectation

module linked_list_engine_core_tb;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 600;
    localparam int FILL_AFTER     = 100;   // random transactions before the store is filled
    localparam int CALM_ITEMS     = 50;    // closing stretch with no idling on either side
    localparam int LONG_HOLD      = 400;   // one long receiver hold-off, in cycles
    localparam int HOLD_AFTER     = 80;    // results seen before that hold-off starts
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES  = 12;

    // op codes that carry no operation
    localparam logic [lle_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [lle_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [lle_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [lle_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    localparam lle_pkg::result_t NO_RES    = '0;
    localparam lle_pkg::result_t RES_OK    =
        '{status: lle_pkg::ST_OK, value_out: '0, index_out: '0};
    localparam lle_pkg::result_t RES_EMPTY =
        '{status: lle_pkg::ST_EMPTY, value_out: '0, index_out: '0};
    localparam lle_pkg::result_t RES_MISS  =
        '{status: lle_pkg::ST_NOT_FOUND, value_out: '0, index_out: '0};

    typedef enum int {
        SEG_GROW,
        SEG_SHRINK,
        SEG_MIXED
    } segment_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        lle_pkg::item_t   stim;
        logic             typed;
        lle_pkg::result_t want;
    } step_row_t;

    step_row_t directed_steps [DIRECTED_ROWS] = '{
        // empty list: pop, remove, find, clear
        '{'{lle_pkg::OP_TAKE_HEAD, 32'sd0}, 1'b1, RES_EMPTY},
        '{'{lle_pkg::OP_REMOVE, 32'sd0}, 1'b1, RES_MISS},
        '{'{lle_pkg::OP_FIND, VAL_MIN}, 1'b1, RES_MISS},
        '{'{lle_pkg::OP_CLEAR, 32'sd0}, 1'b1, RES_OK},
        // spare op codes leave everything alone
        '{'{OP_SPARE_6, 32'sd0}, 1'b1, RES_OK},
        '{'{OP_SPARE_7, -32'sd1}, 1'b1, RES_OK},
        // build 0, max, min, -1 from both ends
        '{'{lle_pkg::OP_ADD_HEAD, VAL_MAX}, 1'b1, RES_OK},
        '{'{lle_pkg::OP_ADD_TAIL, VAL_MIN}, 1'b1, RES_OK},
        '{'{lle_pkg::OP_ADD_HEAD, 32'sd0}, 1'b1, RES_OK},
        '{'{lle_pkg::OP_ADD_TAIL, -32'sd1}, 1'b1, RES_OK},
        '{'{lle_pkg::OP_FIND, VAL_MIN}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_FIND, -32'sd1}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_FIND, 32'sd12345}, 1'b0, NO_RES},
        // unlink middle, then tail, then check the tail pointer with a tail insert
        '{'{lle_pkg::OP_REMOVE, VAL_MAX}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_REMOVE, -32'sd1}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_ADD_TAIL, 32'sd5}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_REMOVE, 32'sd0}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_TAKE_HEAD, 32'sd0}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_TAKE_HEAD, VAL_MAX}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_TAKE_HEAD, 32'sd0}, 1'b1, RES_EMPTY},
        // duplicates: the first match wins
        '{'{lle_pkg::OP_ADD_TAIL, 32'sd42}, 1'b1, RES_OK},
        '{'{lle_pkg::OP_ADD_TAIL, 32'sd42}, 1'b1, RES_OK},
        '{'{lle_pkg::OP_FIND, 32'sd42}, 1'b0, NO_RES},
        '{'{lle_pkg::OP_CLEAR, VAL_MAX}, 1'b1, RES_OK},
        '{'{lle_pkg::OP_FIND, 32'sd42}, 1'b1, RES_MISS}
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    lle_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    lle_pkg::result_t result;

    // mirror of the list contents, head first
    logic signed [lle_pkg::VALUE_W-1:0] list_mirror [$];
    // results still owed by the engine, oldest first
    lle_pkg::result_t pending_results [$];

    int items_in       = 0;
    int results_out    = 0;
    int failures       = 0;
    int idle_cycles    = 0;
    int sender_quiet   = 0;
    int full_hits      = 0;
    int empty_hits     = 0;
    int miss_hits      = 0;
    int peak_depth     = 0;
    int deepest_find   = 0;
    bit calm           = 1'b0;
    bit long_hold_done = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    linked_list_engine_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // applies one operation to the mirror and returns the result it should give;
    // the store is full exactly when the list holds CAPACITY entries, since every
    // node is either linked, on the free chain or above the never-used mark
    function automatic lle_pkg::result_t apply_list_op(lle_pkg::item_t it);
        lle_pkg::result_t r;
        int               hit;
        r   = '0;
        hit = -1;
        case (it.op)
            lle_pkg::OP_ADD_HEAD, lle_pkg::OP_ADD_TAIL:
            begin
                if (list_mirror.size() >= lle_pkg::CAPACITY)
                    r.status = lle_pkg::ST_FULL;
                else if (it.op == lle_pkg::OP_ADD_HEAD)
                    list_mirror = {it.value, list_mirror};
                else
                    list_mirror = {list_mirror, it.value};
            end
            lle_pkg::OP_TAKE_HEAD:
            begin
                if (list_mirror.size() == 0)
                    r.status = lle_pkg::ST_EMPTY;
                else
                begin
                    r.value_out = list_mirror[0];
                    list_mirror.delete(0);
                end
            end
            lle_pkg::OP_REMOVE, lle_pkg::OP_FIND:
            begin
                foreach (list_mirror[i])
                    if (hit < 0 && list_mirror[i] == it.value)
                        hit = i;
                if (hit < 0)
                    r.status = lle_pkg::ST_NOT_FOUND;
                else if (it.op == lle_pkg::OP_FIND)
                    r.index_out = lle_pkg::INDEX_W'(hit);
                else
                begin
                    r.value_out = list_mirror[hit];
                    list_mirror.delete(hit);
                end
            end
            lle_pkg::OP_CLEAR:
                list_mirror.delete();
            default:
                ;
        endcase
        return r;
    endfunction

    // search values lean on what is in the list so remove and find mostly hit
    function automatic logic signed [lle_pkg::VALUE_W-1:0] pick_value(bit from_list);
        if (from_list && list_mirror.size() != 0 && $urandom_range(0, 3) != 0)
            return list_mirror[$urandom_range(0, list_mirror.size() - 1)];
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return $urandom;
            default: return int'($urandom_range(0, 15)) - 8;   // small pool, many repeats
        endcase
    endfunction

    function automatic lle_pkg::item_t random_item(segment_t seg);
        lle_pkg::item_t it;
        int             roll;
        roll = $urandom_range(0, 99);
        case (seg)
            SEG_GROW:
                it.op = roll < 45 ? lle_pkg::OP_ADD_TAIL : roll < 80 ? lle_pkg::OP_ADD_HEAD :
                        roll < 92 ? lle_pkg::OP_FIND : lle_pkg::OP_REMOVE;
            SEG_SHRINK:
                it.op = roll < 45 ? lle_pkg::OP_TAKE_HEAD : roll < 80 ? lle_pkg::OP_REMOVE :
                        roll < 95 ? lle_pkg::OP_FIND : lle_pkg::OP_ADD_TAIL;
            default:
                it.op = roll < 20 ? lle_pkg::OP_ADD_HEAD : roll < 40 ? lle_pkg::OP_ADD_TAIL :
                        roll < 55 ? lle_pkg::OP_TAKE_HEAD : roll < 70 ? lle_pkg::OP_REMOVE :
                        roll < 90 ? lle_pkg::OP_FIND : roll < 93 ? lle_pkg::OP_CLEAR :
                        roll < 97 ? OP_SPARE_6 : OP_SPARE_7;
        endcase
        // pop, clear and the spare codes ignore the value, so any bits go there
        it.value = pick_value(it.op == lle_pkg::OP_REMOVE || it.op == lle_pkg::OP_FIND);
        return it;
    endfunction

    // offers one transaction, holds it until taken, then records what it should give
    // and maybe opens a gap before the next one
    task automatic offer_item(lle_pkg::item_t it, bit typed, lle_pkg::result_t want);
        lle_pkg::result_t predicted;
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        predicted = apply_list_op(it);
        pending_results = {pending_results, typed ? want : predicted};
        items_in++;
        case (predicted.status)
            lle_pkg::ST_FULL:      full_hits++;
            lle_pkg::ST_EMPTY:     empty_hits++;
            lle_pkg::ST_NOT_FOUND: miss_hits++;
            default:               ;
        endcase
        if (list_mirror.size() > peak_depth)
            peak_depth = list_mirror.size();
        if (it.op == lle_pkg::OP_FIND && predicted.status == lle_pkg::ST_OK &&
            predicted.index_out > deepest_find)
            deepest_find = predicted.index_out;
        if (calm || sender_quiet > 0)
        begin
            if (sender_quiet > 0)
                sender_quiet--;
        end
        else if ($urandom_range(0, 19) == 0)
            sender_quiet = $urandom_range(10, 40);
        else if ($urandom_range(0, 2) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic offer_op(logic [lle_pkg::OP_W-1:0] op,
                            logic signed [lle_pkg::VALUE_W-1:0] value);
        lle_pkg::item_t it;
        it.op    = op;
        it.value = value;
        offer_item(it, 1'b0, NO_RES);
    endtask

    // fills the store with distinct values, then works at full depth: full inserts, finds at
    // the last and middle positions, a tail removal and reuse of a freed node
    task automatic fill_store();
        logic signed [lle_pkg::VALUE_W-1:0] base;
        base = $urandom;
        offer_op(lle_pkg::OP_CLEAR, 32'sd0);
        for (int i = 0; i < lle_pkg::CAPACITY; i++)
            offer_op(lle_pkg::OP_ADD_TAIL, base + i);
        offer_op(lle_pkg::OP_ADD_HEAD, VAL_MIN);
        offer_op(lle_pkg::OP_ADD_TAIL, VAL_MAX);
        offer_op(lle_pkg::OP_FIND, base + lle_pkg::CAPACITY - 1);
        offer_op(lle_pkg::OP_FIND, base + lle_pkg::CAPACITY / 2);
        offer_op(lle_pkg::OP_REMOVE, base + lle_pkg::CAPACITY - 1);
        offer_op(lle_pkg::OP_ADD_TAIL, base);
        offer_op(lle_pkg::OP_ADD_HEAD, base);
        offer_op(lle_pkg::OP_FIND, base);
        offer_op(lle_pkg::OP_REMOVE, base + 7);
        offer_op(lle_pkg::OP_TAKE_HEAD, 32'sd0);
    endtask

    // result side: random stall bursts, quiet stretches, and one long hold-off
    // during which the engine keeps its result and stalls new transactions
    initial
    begin : receiver
        int quiet_left;
        quiet_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && results_out >= HOLD_AFTER)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall   <= 1'b0;
                long_hold_done = 1'b1;
            end
            else if (calm || quiet_left > 0)
            begin
                if (quiet_left > 0)
                    quiet_left--;
            end
            else if ($urandom_range(0, 39) == 0)
                quiet_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // compares each result transaction with the oldest pending expectation
    always @(posedge clk)
    begin
        lle_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_out++;
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none, actual %0d / %0d / %0d",
                         $time, result.status, result.value_out, result.index_out);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (^result === 1'bx)
                begin
                    failures++;
                    $display("%0t: unknown bits in result, expected %h, actual %h",
                             $time, want, result);
                end
                else
                begin
                    check_field("status", want.status, result.status);
                    check_field("value_out", longint'(want.value_out),
                                longint'(result.value_out));
                    check_field("index_out", want.index_out, result.index_out);
                end
            end
        end
    end

    // watchdog: any transaction on either side restarts the count
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("linked_list_engine_core test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        segment_t seg;
        int       seg_len;
        int       roll;
        bit       store_filled;
        store_filled = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_steps[i])
            offer_item(directed_steps[i].stim, directed_steps[i].typed, directed_steps[i].want);

        // random segments, with one pass through a completely full store
        while (items_in < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            if (!store_filled && items_in >= DIRECTED_ROWS + FILL_AFTER)
            begin
                fill_store();
                store_filled = 1'b1;
            end
            else
            begin
                roll    = $urandom_range(0, 99);
                seg     = roll < 35 ? SEG_GROW : roll < 60 ? SEG_SHRINK : SEG_MIXED;
                seg_len = $urandom_range(4, 24);
                repeat (seg_len)
                begin
                    calm = items_in >= DIRECTED_ROWS + RANDOM_ITEMS - CALM_ITEMS;
                    offer_item(random_item(seg), 1'b0, NO_RES);
                end
            end
        end
        item_valid <= 1'b0;

        // drain, then give a stray result a chance to show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d transactions in and %0d out: %0d store-full, %0d empty, %0d misses",
                 items_in, results_out, full_hits, empty_hits, miss_hits);
        $display("list reached %0d entries; deepest find hit at position %0d",
                 peak_depth, deepest_find);
        if (failures == 0)
            $display("linked_list_engine_core test passed");
        else
            $display("linked_list_engine_core test failed");
        $finish;
    end

endmodule
